/* hdl/burnwire_sequencer_top_assert.svh */
// assertion macros shared by the rtl files
// the macros expect clk and rst in the scope where they are used
`ifndef BURNWIRE_SEQUENCER_TOP_ASSERT_SVH
`define BURNWIRE_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// consequent checked in the same cycle as the antecedent
`define BWS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// consequent checked in the cycle after the antecedent
`define BWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BWS_ASSERT_SAME(lbl, ante, cons)
`define BWS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/bws_pkg.sv */
package bws_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned ATTEMPT_W = 16;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TIME_W-1:0]    BURN_TIME_RESET  = 32'd500;
  localparam logic [TIME_W-1:0]    DELAY_TIME_RESET = 32'd1000;
  localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX      = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BURN_TIME  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TIME = 1'd1;

  typedef enum logic [PHASE_W-1:0] {
    PH_STANDBY = 2'd0,
    PH_BURN    = 2'd1,
    PH_DELAY   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [TIME_W-1:0] burn_time_ms;
    logic [TIME_W-1:0] delay_time_ms;
  } bws_cfg_t;

  typedef struct packed {
    logic                 wire_one_on;
    logic                 wire_two_on;
    logic [PHASE_W-1:0]   phase;
    logic [ATTEMPT_W-1:0] attempt_count;
  } bws_result_t;

endpackage

/* hdl/bws_channels.sv */
interface bws_poll_if;
  logic                       valid;
  logic                       ready;
  logic [bws_pkg::TIME_W-1:0] now_ms;
  logic                       burn_requested;

  modport source (output valid, output now_ms, output burn_requested, input ready);
  modport sink (input valid, input now_ms, input burn_requested, output ready);
endinterface

interface bws_result_if;
  logic                          valid;
  logic                          ready;
  logic                          wire_one_on;
  logic                          wire_two_on;
  logic [bws_pkg::PHASE_W-1:0]   phase;
  logic [bws_pkg::ATTEMPT_W-1:0] attempt_count;

  modport source (output valid, output wire_one_on, output wire_two_on, output phase,
                  output attempt_count, input ready);
  modport sink (input valid, input wire_one_on, input wire_two_on, input phase,
                input attempt_count, output ready);
endinterface

/* hdl/burnwire_sequencer_top.sv */
// burn-wire sequencer: one poll in, one result out per transaction
// a poll is held in the input stage, then its result in the output stage
// throughput: one poll per cycle while results are taken; the sequencer state is a single
//   register set updated in one step, so consecutive polls never wait on each other
// reset (rst, synchronous): standby, both wires off, attempt count zero,
//   burn time 500 ms, delay time 1000 ms, input and output stages empty
`include "burnwire_sequencer_top_assert.svh"

module burnwire_sequencer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bws_pkg::TIME_W-1:0]    cfg_data,
  bws_poll_if.sink                      poll,
  bws_result_if.source                  result
);
  import bws_pkg::*;

  // configuration registers
  bws_cfg_t          cfg;

  // input stage: holds one accepted poll transaction
  logic              in_valid;
  logic [TIME_W-1:0] in_now_ms;
  logic              in_burn_req;

  // output stage: holds one finished result transaction
  logic              out_valid;
  bws_result_t       out_res;

  bws_result_t       step_res;
  logic              advance;

  // the input stage moves on whenever the output stage is empty or being drained
  assign advance    = in_valid && (!out_valid || result.ready);
  // a new poll is taken while the previous one moves on, so one per cycle sustained
  assign poll.ready = !in_valid || advance;

  // configuration writes; out-of-range indexes cannot be encoded with one index bit
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burn_time_ms  <= BURN_TIME_RESET;
      cfg.delay_time_ms <= DELAY_TIME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BURN_TIME:  cfg.burn_time_ms  <= cfg_data;
        CFG_DELAY_TIME: cfg.delay_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      in_now_ms   <= poll.now_ms;
      in_burn_req <= poll.burn_requested;
    end
  end

  // sequencer state and next-step logic; state commits only when the poll advances
  bws_core u_core (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .now_ms         (in_now_ms),
    .burn_requested (in_burn_req),
    .cfg            (cfg),
    .res            (step_res)
  );

  // result register; holds while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.wire_one_on   = out_res.wire_one_on;
  assign result.wire_two_on   = out_res.wire_two_on;
  assign result.phase         = out_res.phase;
  assign result.attempt_count = out_res.attempt_count;

  // a stalled result must not be overwritten
  `BWS_ASSERT_SAME(a_no_overwrite, out_valid && !result.ready, !advance)
  // a poll moving on always shows up as a result next cycle
  `BWS_ASSERT_NEXT(a_advance_delivers, advance, out_valid)
  // while both stages are full and the sink stalls, no new poll is taken
  `BWS_ASSERT_SAME(a_full_blocks, in_valid && out_valid && !result.ready, !poll.ready)

endmodule

/* hdl/bws_core.sv */
`include "burnwire_sequencer_top_assert.svh"

module bws_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [bws_pkg::TIME_W-1:0] now_ms,
  input  logic                       burn_requested,
  input  bws_pkg::bws_cfg_t          cfg,
  output bws_pkg::bws_result_t       res
);
  import bws_pkg::*;

  phase_t                phase_reg;
  logic [TIME_W-1:0]     phase_start_ms;
  logic [ATTEMPT_W-1:0]  attempts_reg;
  logic                  next_wire_two;

  phase_t                phase_next;
  logic [TIME_W-1:0]     phase_start_next;
  logic [ATTEMPT_W-1:0]  attempts_next;
  logic                  next_wire_two_next;
  logic [TIME_W-1:0]     elapsed;
  logic                  fire;

  // wrapping subtraction
  assign elapsed = now_ms - phase_start_ms;

  always_comb begin
    phase_next         = phase_reg;
    phase_start_next   = phase_start_ms;
    attempts_next      = attempts_reg;
    next_wire_two_next = next_wire_two;
    fire               = 1'b0;
    if (!burn_requested) begin
      phase_next         = PH_STANDBY;
      attempts_next      = '0;
      next_wire_two_next = 1'b0;
    end else begin
      unique case (phase_reg)
        PH_BURN: begin
          if (elapsed >= cfg.burn_time_ms) begin
            phase_next       = PH_DELAY;
            phase_start_next = now_ms;
          end
        end
        PH_DELAY: begin
          fire = (elapsed >= cfg.delay_time_ms);
        end
        default: begin
          fire = 1'b1;
        end
      endcase
      if (fire) begin
        phase_next         = PH_BURN;
        phase_start_next   = now_ms;
        next_wire_two_next = ~next_wire_two;
        attempts_next      = (attempts_reg == ATTEMPT_MAX) ? attempts_reg
                                                           : attempts_reg + 1'b1;
      end
    end
  end

  // toggled on firing, so the wire that just fired is the opposite of next_wire_two
  always_comb begin
    res.wire_one_on   = (phase_next == PH_BURN) && next_wire_two_next;
    res.wire_two_on   = (phase_next == PH_BURN) && !next_wire_two_next;
    res.phase         = phase_next;
    res.attempt_count = attempts_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= PH_STANDBY;
      phase_start_ms <= '0;
      attempts_reg   <= '0;
      next_wire_two  <= 1'b0;
    end else if (en) begin
      phase_reg      <= phase_next;
      phase_start_ms <= phase_start_next;
      attempts_reg   <= attempts_next;
      next_wire_two  <= next_wire_two_next;
    end
  end

  `BWS_ASSERT_NEXT(a_drop_clears, en && !burn_requested,
                   phase_reg == PH_STANDBY && attempts_reg == '0 && !next_wire_two)
  `BWS_ASSERT_NEXT(a_standby_fires, en && burn_requested && phase_reg == PH_STANDBY,
                   phase_reg == PH_BURN && attempts_reg != '0 && next_wire_two)
  `BWS_ASSERT_NEXT(a_hold_when_idle, !en,
                   $stable(phase_reg) && $stable(attempts_reg) && $stable(phase_start_ms))
  `BWS_ASSERT_SAME(a_wires_follow_phase, en,
                   (res.wire_one_on || res.wire_two_on) == (res.phase == PH_BURN))

endmodule

/* tb/burnwire_sequencer_checker.sv */
`timescale 1ns / 100ps

module burnwire_sequencer_checker
  import bws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  bws_poll_if                  poll,
  bws_result_if                result,
  output int unsigned          mismatch_total,
  output int unsigned          pending_count
);

  // shadow of the configuration registers
  logic [TIME_W-1:0]    burn_limit;
  logic [TIME_W-1:0]    delay_limit;

  // shadow of the sequencer state
  phase_t               seq_phase;
  logic [TIME_W-1:0]    seq_start_ms;
  logic [ATTEMPT_W-1:0] seq_attempts;
  logic                 seq_wire_two_next;

  bws_result_t          expected_status_q[$];
  int unsigned          error_count;

  function automatic void fire_wire(input logic [TIME_W-1:0] now);
    seq_phase         = PH_BURN;
    seq_start_ms      = now;
    seq_wire_two_next = ~seq_wire_two_next;
    if (seq_attempts != ATTEMPT_MAX)
      seq_attempts = seq_attempts + 1'b1;
  endfunction

  function automatic bws_result_t advance_sequencer(input logic [TIME_W-1:0] now,
                                                    input logic req);
    logic [TIME_W-1:0] elapsed;
    bws_result_t       status;
    elapsed = now - seq_start_ms;
    if (!req) begin
      seq_phase         = PH_STANDBY;
      seq_attempts      = '0;
      seq_wire_two_next = 1'b0;
    end else begin
      case (seq_phase)
        PH_BURN: begin
          if (elapsed >= burn_limit) begin
            seq_phase    = PH_DELAY;
            seq_start_ms = now;
          end
        end
        PH_DELAY: begin
          if (elapsed >= delay_limit)
            fire_wire(now);
        end
        default: begin
          fire_wire(now);
        end
      endcase
    end
    // the toggle already happened, so the fired wire is the opposite of next
    status.wire_one_on   = (seq_phase == PH_BURN) && seq_wire_two_next;
    status.wire_two_on   = (seq_phase == PH_BURN) && !seq_wire_two_next;
    status.phase         = seq_phase;
    status.attempt_count = seq_attempts;
    return status;
  endfunction

  always @(posedge clk) begin : watch
    bws_result_t got;
    bws_result_t want;
    if (rst) begin
      burn_limit        = BURN_TIME_RESET;
      delay_limit       = DELAY_TIME_RESET;
      seq_phase         = PH_STANDBY;
      seq_start_ms      = '0;
      seq_attempts      = '0;
      seq_wire_two_next = 1'b0;
      expected_status_q.delete();
      error_count       = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BURN_TIME:  burn_limit  = cfg_data;
          CFG_DELAY_TIME: delay_limit = cfg_data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        got.wire_one_on   = result.wire_one_on;
        got.wire_two_on   = result.wire_two_on;
        got.phase         = result.phase;
        got.attempt_count = result.attempt_count;
        if (expected_status_q.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10)
            $display("unexpected result at %0t: w1=%0b w2=%0b phase=%0d attempts=%0d",
                     $time, got.wire_one_on, got.wire_two_on, got.phase, got.attempt_count);
        end else begin
          want = expected_status_q.pop_front();
          if (got.wire_one_on !== want.wire_one_on || got.wire_two_on !== want.wire_two_on ||
              got.phase !== want.phase || got.attempt_count !== want.attempt_count) begin
            error_count = error_count + 1;
            if (error_count <= 10)
              $display("mismatch at %0t: expected w1=%0b w2=%0b phase=%0d attempts=%0d, %s",
                       $time, want.wire_one_on, want.wire_two_on, want.phase,
                       want.attempt_count,
                       $sformatf("got w1=%0b w2=%0b phase=%0d attempts=%0d",
                                 got.wire_one_on, got.wire_two_on, got.phase,
                                 got.attempt_count));
          end
        end
      end
      if (poll.valid && poll.ready)
        expected_status_q.push_back(advance_sequencer(poll.now_ms, poll.burn_requested));
    end
    mismatch_total <= error_count;
    pending_count  <= expected_status_q.size();
  end

endmodule

/* tb/burnwire_sequencer_top_tb.sv */
`timescale 1ns / 100ps

module burnwire_sequencer_top_tb;
  import bws_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_data;

  int unsigned          mismatch_total;
  int unsigned          pending_count;

  // running millisecond clock handed to the sequencer
  logic [TIME_W-1:0]    now_cursor;

  bws_poll_if   poll_ch();
  bws_result_if result_ch();

  burnwire_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .poll      (poll_ch),
    .result    (result_ch)
  );

  burnwire_sequencer_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .poll           (poll_ch),
    .result         (result_ch),
    .mismatch_total (mismatch_total),
    .pending_count  (pending_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one poll transaction and hold it until the sequencer takes it;
  // valid is only lowered when a gap is drawn, so back-to-back polls keep it high
  task automatic send_poll(input logic [TIME_W-1:0] now, input logic req, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_ch.valid          <= 1'b1;
    poll_ch.now_ms         <= now;
    poll_ch.burn_requested <= req;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
  endtask

  // stop offering polls and wait until every expected status has come back,
  // then wait on so the two-stage pipeline is fully drained
  task automatic drain_results();
    poll_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write burn time, then delay time, back to back
  task automatic set_times(input logic [TIME_W-1:0] burn, input logic [TIME_W-1:0] delay);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BURN_TIME;
    cfg_data  <= burn;
    @(posedge clk);
    cfg_index <= CFG_DELAY_TIME;
    cfg_data  <= delay;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // status receiver: random stalls, calm stretches, and one long hold-off
  // so the sequencer fills its stages and pushes back on the poll side
  initial begin : status_sink
    int unsigned taken;
    int unsigned stall;
    taken = 0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 150)
        stall = 40;
      else if ((taken / 50) % 6 == 3)
        stall = 0;
      else
        stall = $urandom_range(0, 3);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      taken = taken + 1;
    end
  end

  // poll stimulus and verdict
  initial begin : poll_source
    logic [TIME_W-1:0] burn_sel;
    logic [TIME_W-1:0] delay_sel;
    int unsigned       step_max;
    int unsigned       roll;
    bit                req;
    bit                wide_steps;

    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_BURN_TIME;
    cfg_data               <= '0;
    poll_ch.valid          <= 1'b0;
    poll_ch.now_ms         <= '0;
    poll_ch.burn_requested <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset times 500 / 1000: full burn-delay-burn cycle with alternating wires
    send_poll(32'd0,    1'b0, 1'b0);   // idle poll in standby
    send_poll(32'd100,  1'b1, 1'b0);   // fire first wire
    send_poll(32'd599,  1'b1, 1'b0);   // one short of burn end
    send_poll(32'd600,  1'b1, 1'b0);   // burn ends exactly
    send_poll(32'd1599, 1'b1, 1'b0);
    send_poll(32'd1600, 1'b1, 1'b0);   // second wire fires
    send_poll(32'd2100, 1'b1, 1'b0);
    send_poll(32'd3100, 1'b1, 1'b0);   // back to first wire, attempt three
    send_poll(32'd3200, 1'b0, 1'b0);   // request dropped mid-burn
    send_poll(32'd3300, 1'b1, 1'b0);   // alternation restarts on first wire
    send_poll(32'd3300, 1'b0, 1'b0);
    drain_results();

    // zero times: each phase lasts exactly one poll
    set_times('0, '0);
    send_poll(32'd10, 1'b1, 1'b0);
    send_poll(32'd10, 1'b1, 1'b0);
    send_poll(32'd10, 1'b1, 1'b0);
    send_poll(32'd10, 1'b1, 1'b0);
    drain_results();

    // all-ones times only end on a full wrap of elapsed time
    set_times('1, '1);
    send_poll(32'hFFFF_FF00, 1'b1, 1'b0);
    send_poll(32'hFFFF_FEFF, 1'b1, 1'b0);   // elapsed all ones ends the burn
    send_poll(32'hFFFF_FEFE, 1'b1, 1'b0);   // and the delay as well
    send_poll(32'd0,         1'b0, 1'b0);
    drain_results();

    // elapsed time across the 32-bit wrap of the millisecond counter
    set_times(32'd20, 32'd7);
    send_poll(32'hFFFF_FFF8, 1'b1, 1'b0);
    send_poll(32'd4,         1'b1, 1'b0);
    send_poll(32'd12,        1'b1, 1'b0);
    send_poll(32'd18,        1'b1, 1'b0);
    send_poll(32'd19,        1'b1, 1'b0);
    send_poll(32'd19,        1'b0, 1'b0);
    drain_results();

    // random phases, each with its own pair of times; mostly requested polls
    // with a moving clock, some dropped requests and some jumps of the clock
    now_cursor = $urandom;
    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      wide_steps = 1'b0;
      step_max   = 40;
      case (phase_no)
        0: begin
          burn_sel  = $urandom_range(1, 16);
          delay_sel = $urandom_range(1, 16);
        end
        1: begin
          burn_sel  = '0;
          delay_sel = $urandom_range(0, 8);
        end
        2: begin
          burn_sel  = $urandom_range(0, 8);
          delay_sel = '0;
        end
        3: begin
          burn_sel  = '1;
          delay_sel = $urandom_range(1, 10);
        end
        4: begin
          burn_sel   = $urandom;
          delay_sel  = $urandom;
          wide_steps = 1'b1;
        end
        default: begin
          burn_sel  = $urandom_range(1, 40);
          delay_sel = $urandom_range(1, 40);
          step_max  = 90;
        end
      endcase
      set_times(burn_sel, delay_sel);
      for (int k = 0; k < 125; k++) begin
        roll = $urandom_range(0, 99);
        req  = (roll >= 8);
        if (roll < 4)
          now_cursor = $urandom;                  // noise: clock jumps anywhere
        else if (roll < 12)
          now_cursor = now_cursor - 1'b1;         // clock steps back, elapsed near all ones
        else if (wide_steps)
          now_cursor = now_cursor + $urandom;
        else
          now_cursor = now_cursor + $urandom_range(0, step_max);
        send_poll(now_cursor, req, (k / 40) % 5 == 3);
      end
      // a full pause of the poll side between phases
      drain_results();
    end

    // wind down: nothing left to send, wait for the tail of the results
    drain_results();
    repeat (10) @(posedge clk);

    if (mismatch_total == 0 && pending_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // run limit, well beyond the slowest legal run
  initial begin : run_limit
    #30000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
